// ===== design/asr_envelope_pwm_level_top_macros.svh =====
// Assertion macros for the envelope level generator.
// Included by the top level; needs nothing else.
`ifndef ASR_ENVELOPE_PWM_LEVEL_TOP_MACROS_SVH
`define ASR_ENVELOPE_PWM_LEVEL_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASPL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASPL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/aspl_pkg.sv =====
// Shared widths, register indexes, datapath commands and status for the
// envelope level generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aspl_pkg;

   localparam int LEVEL_MAX = 4095;
   localparam int LEVEL_W   = 12;
   localparam int TIME_W    = 64;
   localparam int PER_W     = 32;
   localparam int WGT_W     = 8;
   localparam int WSUM_W    = WGT_W + 2;
   localparam int TRIG_W    = 4;
   localparam int PEND_W    = 8;
   localparam int PEND_MAX  = 255;
   localparam int DIV_W     = 64;
   localparam int ITER_W    = 7;
   localparam int DRV_BITS  = PER_W + WGT_W;
   localparam int RAMP_BITS = PER_W + $clog2(LEVEL_MAX + 1);

   localparam int CSR_AW    = 6;
   localparam int CSR_DW    = 64;
   localparam int IDX_LSB   = 3;
   localparam int IDX_W     = 3;

   localparam int REQ_DW    = 136;
   localparam int RSP_DW    = 16;

   typedef enum logic [IDX_W-1:0] {
      REG_PERIOD  = 3'd0,
      REG_ATTACK  = 3'd1,
      REG_SUSTAIN = 3'd2,
      REG_RELEASE = 3'd3,
      REG_MODE    = 3'd4,
      REG_ANCHOR  = 3'd5
   } reg_idx_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_DRV_A,
      CMD_DRV_S,
      CMD_DRV_FIX1,
      CMD_DRV_FIX2,
      CMD_DRV_ZERO,
      CMD_MOD,
      CMD_MOD_DONE,
      CMD_TRIG,
      CMD_OS_EVAL,
      CMD_SEG_S,
      CMD_SEG_R,
      CMD_RAMP_A,
      CMD_RAMP_R,
      CMD_LVL_RAMP,
      CMD_LVL_MAX,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic [PER_W-1:0]  period;
      logic [WGT_W-1:0]  attack_w;
      logic [WGT_W-1:0]  sustain_w;
      logic [WGT_W-1:0]  release_w;
      logic              loop_mode;
      logic [TIME_W-1:0] anchor;
      logic              dirty;
   } cfg_type;

   typedef struct packed {
      logic div_done;
      logic drv_ok;
      logic trans_due;
      logic loop_go;
      logic pend_nz;
      logic act;
      logic in_range;
      logic lt_a;
      logic lt_s;
      logic lt_r;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== design/aspl_csr.sv =====
// Configuration registers with APB-style access and a flag that marks
// the segment lengths stale after a write. Uses aspl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aspl_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [aspl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [aspl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [aspl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   input  aspl_pkg::cmd_type           cmd,
   output aspl_pkg::cfg_type           cfg
);
   import aspl_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign csr_pready = 1'b1;
   assign idx        = reg_idx_type'(csr_paddr[IDX_LSB +: IDX_W]);
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      // lengths are rebuilt before the next tick is evaluated
      if ((cmd == CMD_DRV_FIX2) || (cmd == CMD_DRV_ZERO)) begin
         cfg_in.dirty = 1'b0;
      end
      if (wr) begin
         unique case (idx)
            REG_PERIOD: begin
               cfg_in.period = csr_pwdata[PER_W-1:0];
               cfg_in.dirty  = 1'b1;
            end
            REG_ATTACK: begin
               cfg_in.attack_w = csr_pwdata[WGT_W-1:0];
               cfg_in.dirty    = 1'b1;
            end
            REG_SUSTAIN: begin
               cfg_in.sustain_w = csr_pwdata[WGT_W-1:0];
               cfg_in.dirty     = 1'b1;
            end
            REG_RELEASE: begin
               cfg_in.release_w = csr_pwdata[WGT_W-1:0];
               cfg_in.dirty     = 1'b1;
            end
            REG_MODE: begin
               cfg_in.loop_mode = csr_pwdata[0];
               cfg_in.dirty     = 1'b1;
            end
            REG_ANCHOR: begin
               cfg_in.anchor = csr_pwdata[TIME_W-1:0];
               cfg_in.dirty  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PERIOD:  csr_prdata = CSR_DW'(cfg_ff.period);
         REG_ATTACK:  csr_prdata = CSR_DW'(cfg_ff.attack_w);
         REG_SUSTAIN: csr_prdata = CSR_DW'(cfg_ff.sustain_w);
         REG_RELEASE: csr_prdata = CSR_DW'(cfg_ff.release_w);
         REG_MODE:    csr_prdata = CSR_DW'(cfg_ff.loop_mode);
         REG_ANCHOR:  csr_prdata = CSR_DW'(cfg_ff.anchor);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/aspl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, with a settable
// step count for dividends aligned to the top bit. Uses aspl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aspl_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aspl_pkg::DIV_W-1:0]  dividend,
   input  logic [aspl_pkg::PER_W-1:0]  divisor,
   input  logic [aspl_pkg::ITER_W-1:0] iters,
   output logic                        done,
   output logic [aspl_pkg::DIV_W-1:0]  quot,
   output logic [aspl_pkg::PER_W-1:0]  rem
);
   import aspl_pkg::*;

   logic [DIV_W-1:0]  q_ff, q_in;
   logic [PER_W-1:0]  r_ff, r_in;
   logic [PER_W-1:0]  d_ff, d_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [PER_W:0]    trial;
   logic [PER_W:0]    diff;
   logic              fits;

   assign trial = {r_ff, q_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = iters;
         run_in = 1'b1;
      end else if (run_ff) begin
         r_in   = fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
         q_in   = {q_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

`default_nettype wire

// ===== design/aspl_dp.sv =====
// Datapath: tick capture, trigger count, one-shot state, segment lengths,
// envelope position and level; owns the shared divider. Uses aspl_pkg, aspl_div.
`timescale 1ns / 1ps
`default_nettype none

module aspl_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  aspl_pkg::cmd_type            cmd,
   input  aspl_pkg::cfg_type            cfg,
   input  logic [aspl_pkg::TIME_W-1:0]  now_us,
   input  logic [aspl_pkg::TRIG_W-1:0]  new_triggers,
   input  logic                         transition_pending,
   input  logic [aspl_pkg::TIME_W-1:0]  transition_time_us,
   output aspl_pkg::dp_sts_type         sts,
   output logic [aspl_pkg::LEVEL_W-1:0] level,
   output logic                         one_shot_running
);
   import aspl_pkg::*;

   localparam logic [PER_W-1:0] PER_MIN  = PER_W'(2);
   localparam logic [PER_W-1:0] PER_BUMP = PER_W'(3);

   function automatic logic [PER_W-1:0] bump(input logic [PER_W-1:0] v,
                                             input logic [WGT_W-1:0] wt,
                                             input logic [PER_W-1:0] p);
      logic keep_one;
      keep_one = (wt != '0) && (v == '0) && (p >= PER_BUMP);
      return keep_one ? PER_W'(1) : v;
   endfunction

   // tick capture
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               tp_ff, tp_in;
   logic [TIME_W-1:0]  tt_ff, tt_in;
   // persistent state
   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic               act_ff, act_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  stop_ff, stop_in;
   logic [PER_W-1:0]   sh_per_ff, sh_per_in;
   logic [PER_W-1:0]   sh_a_ff, sh_a_in, sh_s_ff, sh_s_in, sh_r_ff, sh_r_in;
   logic [PER_W-1:0]   len_a_ff, len_a_in, len_s_ff, len_s_in, len_r_ff, len_r_in;
   // working registers
   logic [PER_W-1:0]   araw_ff, araw_in, sraw_ff, sraw_in;
   logic [PER_W-1:0]   t_ff, t_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [LEVEL_W-1:0] out_lvl_ff, out_lvl_in;
   logic               out_run_ff, out_run_in;

   logic [WSUM_W-1:0]    wsum;
   logic [PER_W-1:0]     la, ls, lr;
   logic [TIME_W-1:0]    loop_diff, os_diff, stop_diff, tr_diff;
   logic [PEND_W:0]      pend_sum;
   logic [DRV_BITS-1:0]  prod_a, prod_s;
   logic [PER_W-1:0]     ramp_num, ramp_len;
   logic [RAMP_BITS-1:0] ramp_x;
   logic [PER_W-1:0]     pm1, fix_a, fix_s, fix_r;
   logic [PER_W:0]       fix_sum;
   logic [RAMP_BITS-1:0] q_top;
   logic [LEVEL_W-1:0]   ramp_lvl;

   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_x, div_q;
   logic [PER_W-1:0]     div_d, div_r;
   logic [ITER_W-1:0]    div_n;

   aspl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_x),
      .divisor  (div_d),
      .iters    (div_n),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   assign wsum = WSUM_W'(cfg.attack_w) + WSUM_W'(cfg.sustain_w) + WSUM_W'(cfg.release_w);

   // loop mode runs on live lengths, one-shot on those latched at its start
   assign la = cfg.loop_mode ? len_a_ff : sh_a_ff;
   assign ls = cfg.loop_mode ? len_s_ff : sh_s_ff;
   assign lr = cfg.loop_mode ? len_r_ff : sh_r_ff;

   assign loop_diff = now_ff - cfg.anchor;
   assign os_diff   = now_ff - start_ff;
   assign stop_diff = now_ff - stop_ff;
   assign tr_diff   = now_ff - tt_ff;

   assign sts.div_done  = div_done;
   assign sts.drv_ok    = (cfg.period >= PER_MIN) && (wsum != '0);
   assign sts.trans_due = tp_ff && !tr_diff[TIME_W-1];
   assign sts.loop_go   = (cfg.period >= PER_MIN) && !loop_diff[TIME_W-1];
   assign sts.pend_nz   = (pend_ff != '0);
   assign sts.act       = act_ff;
   assign sts.in_range  = (sh_per_ff >= PER_MIN) && (os_diff[TIME_W-1:PER_W] == '0)
                          && (os_diff[PER_W-1:0] < sh_per_ff);
   assign sts.lt_a      = t_ff < la;
   assign sts.lt_s      = t_ff < ls;
   assign sts.lt_r      = t_ff < lr;

   assign pend_sum = (PEND_W + 1)'(pend_ff) + (PEND_W + 1)'(new_triggers);

   assign prod_a = DRV_BITS'(cfg.period) * DRV_BITS'(cfg.attack_w);
   assign prod_s = DRV_BITS'(cfg.period) * DRV_BITS'(cfg.sustain_w);

   // rising ramp counts up from the attack start, falling one counts down
   assign ramp_num = (cmd == CMD_RAMP_R) ? (lr - t_ff) : t_ff;
   assign ramp_len = (cmd == CMD_RAMP_R) ? lr : la;
   assign ramp_x   = RAMP_BITS'(ramp_num) * RAMP_BITS'(LEVEL_MAX)
                     + RAMP_BITS'(ramp_len >> 1);

   assign q_top    = div_q[RAMP_BITS-1:0];
   assign ramp_lvl = (q_top > RAMP_BITS'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                     : q_top[LEVEL_W-1:0];

   // clamp attack plus sustain below the period, release takes the rest
   always_comb begin
      pm1     = cfg.period - PER_W'(1);
      fix_a   = araw_ff;
      fix_s   = sraw_ff;
      fix_sum = {1'b0, araw_ff} + {1'b0, sraw_ff};
      if (fix_sum >= {1'b0, cfg.period}) begin
         if (sraw_ff != '0) begin
            fix_s = (araw_ff < pm1) ? (pm1 - araw_ff) : '0;
         end else begin
            fix_a = pm1;
         end
         if (fix_a > pm1) begin
            fix_a = pm1;
         end
      end
      fix_r = cfg.period - fix_a - fix_s;
   end

   always_comb begin
      div_start = 1'b0;
      div_x     = '0;
      div_d     = '0;
      div_n     = '0;
      unique case (cmd)
         CMD_DRV_A: begin
            div_start = 1'b1;
            div_x     = {prod_a, {(DIV_W - DRV_BITS){1'b0}}};
            div_d     = PER_W'(wsum);
            div_n     = ITER_W'(DRV_BITS);
         end
         CMD_DRV_S: begin
            div_start = 1'b1;
            div_x     = {prod_s, {(DIV_W - DRV_BITS){1'b0}}};
            div_d     = PER_W'(wsum);
            div_n     = ITER_W'(DRV_BITS);
         end
         CMD_MOD: begin
            div_start = 1'b1;
            div_x     = loop_diff;
            div_d     = cfg.period;
            div_n     = ITER_W'(DIV_W);
         end
         CMD_RAMP_A, CMD_RAMP_R: begin
            div_start = 1'b1;
            div_x     = {ramp_x, {(DIV_W - RAMP_BITS){1'b0}}};
            div_d     = ramp_len;
            div_n     = ITER_W'(RAMP_BITS);
         end
         default: ;
      endcase
   end

   always_comb begin
      now_in     = now_ff;
      tp_in      = tp_ff;
      tt_in      = tt_ff;
      pend_in    = pend_ff;
      act_in     = act_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      sh_per_in  = sh_per_ff;
      sh_a_in    = sh_a_ff;
      sh_s_in    = sh_s_ff;
      sh_r_in    = sh_r_ff;
      len_a_in   = len_a_ff;
      len_s_in   = len_s_ff;
      len_r_in   = len_r_ff;
      araw_in    = araw_ff;
      sraw_in    = sraw_ff;
      t_in       = t_ff;
      lvl_in     = lvl_ff;
      out_lvl_in = out_lvl_ff;
      out_run_in = out_run_ff;
      unique case (cmd)
         CMD_CAPTURE: begin
            now_in  = now_us;
            tp_in   = transition_pending;
            tt_in   = transition_time_us;
            pend_in = pend_sum[PEND_W] ? PEND_W'(PEND_MAX) : pend_sum[PEND_W-1:0];
            lvl_in  = '0;
         end
         CMD_DRV_S: begin
            araw_in = div_q[PER_W-1:0];
         end
         CMD_DRV_FIX1: begin
            araw_in = bump(araw_ff, cfg.attack_w, cfg.period);
            sraw_in = bump(div_q[PER_W-1:0], cfg.sustain_w, cfg.period);
         end
         CMD_DRV_FIX2: begin
            len_a_in = fix_a;
            len_s_in = fix_s;
            len_r_in = fix_r;
         end
         CMD_DRV_ZERO: begin
            len_a_in = '0;
            len_s_in = '0;
            len_r_in = '0;
         end
         CMD_MOD_DONE: begin
            t_in = div_r;
         end
         CMD_TRIG: begin
            act_in    = 1'b1;
            start_in  = now_ff;
            stop_in   = now_ff + TIME_W'(cfg.period);
            sh_per_in = cfg.period;
            sh_a_in   = len_a_ff;
            sh_s_in   = len_s_ff;
            sh_r_in   = len_r_ff;
            pend_in   = pend_ff - PEND_W'(1);
         end
         CMD_OS_EVAL: begin
            t_in = os_diff[PER_W-1:0];
            if (!stop_diff[TIME_W-1]) begin
               act_in = 1'b0;
            end
         end
         CMD_SEG_S: begin
            t_in = t_ff - la;
         end
         CMD_SEG_R: begin
            t_in = t_ff - ls;
         end
         CMD_LVL_RAMP: begin
            lvl_in = ramp_lvl;
         end
         CMD_LVL_MAX: begin
            lvl_in = LEVEL_W'(LEVEL_MAX);
         end
         CMD_OUT: begin
            out_lvl_in = lvl_ff;
            out_run_in = act_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         act_ff   <= 1'b0;
         len_a_ff <= '0;
         len_s_ff <= '0;
         len_r_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         act_ff   <= act_in;
         len_a_ff <= len_a_in;
         len_s_ff <= len_s_in;
         len_r_ff <= len_r_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      tp_ff      <= tp_in;
      tt_ff      <= tt_in;
      start_ff   <= start_in;
      stop_ff    <= stop_in;
      sh_per_ff  <= sh_per_in;
      sh_a_ff    <= sh_a_in;
      sh_s_ff    <= sh_s_in;
      sh_r_ff    <= sh_r_in;
      araw_ff    <= araw_in;
      sraw_ff    <= sraw_in;
      t_ff       <= t_in;
      lvl_ff     <= lvl_in;
      out_lvl_ff <= out_lvl_in;
      out_run_ff <= out_run_in;
   end

   assign level            = out_lvl_ff;
   assign one_shot_running = out_run_ff;

endmodule

`default_nettype wire

// ===== design/aspl_ctrl.sv =====
// Controller: sequences segment derivation, tick evaluation and the level
// ramp, and owns the result valid flag. Uses aspl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aspl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  aspl_pkg::cfg_type    cfg,
   input  aspl_pkg::dp_sts_type sts,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output aspl_pkg::cmd_type    cmd
);
   import aspl_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_DRV    = 15'b000000000000010,
      S_DRV_AW = 15'b000000000000100,
      S_DRV_SW = 15'b000000000001000,
      S_FIX2   = 15'b000000000010000,
      S_EVAL   = 15'b000000000100000,
      S_MODW   = 15'b000000001000000,
      S_OSEV   = 15'b000000010000000,
      S_SEGA   = 15'b000000100000000,
      S_SEGS   = 15'b000001000000000,
      S_SEGR   = 15'b000010000000000,
      S_RAMPW  = 15'b000100000000000,
      S_DONE   = 15'b001000000000000,
      S_TRIG   = 15'b010000000000000,
      S_SPARE  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = CMD_CAPTURE;
               state_in = cfg.dirty ? S_DRV : S_EVAL;
            end
         end
         S_DRV: begin
            if (sts.drv_ok) begin
               cmd      = CMD_DRV_A;
               state_in = S_DRV_AW;
            end else begin
               cmd      = CMD_DRV_ZERO;
               state_in = S_EVAL;
            end
         end
         S_DRV_AW: begin
            if (sts.div_done) begin
               cmd      = CMD_DRV_S;
               state_in = S_DRV_SW;
            end
         end
         S_DRV_SW: begin
            if (sts.div_done) begin
               cmd      = CMD_DRV_FIX1;
               state_in = S_FIX2;
            end
         end
         S_FIX2: begin
            cmd      = CMD_DRV_FIX2;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // a due shape switch wins over both envelope modes
            priority if (sts.trans_due) begin
               state_in = S_DONE;
            end else if (cfg.loop_mode) begin
               if (sts.loop_go) begin
                  cmd      = CMD_MOD;
                  state_in = S_MODW;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = sts.pend_nz ? S_TRIG : S_OSEV;
            end
         end
         S_TRIG: begin
            cmd      = CMD_TRIG;
            state_in = S_OSEV;
         end
         S_OSEV: begin
            if (sts.act) begin
               cmd      = CMD_OS_EVAL;
               state_in = sts.in_range ? S_SEGA : S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MODW: begin
            if (sts.div_done) begin
               cmd      = CMD_MOD_DONE;
               state_in = S_SEGA;
            end
         end
         S_SEGA: begin
            if (sts.lt_a) begin
               cmd      = CMD_RAMP_A;
               state_in = S_RAMPW;
            end else begin
               cmd      = CMD_SEG_S;
               state_in = S_SEGS;
            end
         end
         S_SEGS: begin
            if (sts.lt_s) begin
               cmd      = CMD_LVL_MAX;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_SEG_R;
               state_in = S_SEGR;
            end
         end
         S_SEGR: begin
            if (sts.lt_r) begin
               cmd      = CMD_RAMP_R;
               state_in = S_RAMPW;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RAMPW: begin
            if (sts.div_done) begin
               cmd      = CMD_LVL_RAMP;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd          = CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/asr_envelope_pwm_level_top.sv =====
// A result is valid once its tick is evaluated, which waits on the radix-2
//   divider (64 steps for the loop position, 44 steps for the level ramp).
// A tick after a register write first rebuilds the segment lengths.
// Ticks are handled one at a time; the next beat is taken while a result waits.
// Reset: synchronous, active high; clears control, trigger and one-shot state.
`timescale 1ns / 1ps
`default_nettype none
`include "asr_envelope_pwm_level_top_macros.svh"

module asr_envelope_pwm_level_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [63:0] now_us, [67:64] new_triggers, [68] transition_pending,
   // [132:69] transition_time_us, [135:133] zero
   input  logic [aspl_pkg::REQ_DW-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [11:0] level, [12] one_shot_running, [15:13] zero
   output logic [aspl_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [aspl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [aspl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [aspl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import aspl_pkg::*;

   localparam int TRIG_LSB = TIME_W;
   localparam int TP_BIT   = TRIG_LSB + TRIG_W;
   localparam int TT_LSB   = TP_BIT + 1;
   localparam int RSP_USED = LEVEL_W + 1;

   cfg_type            cfg;
   cmd_type            cmd;
   dp_sts_type         dp_sts;
   logic [LEVEL_W-1:0] level;
   logic               one_shot_running;

   aspl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd         (cmd),
      .cfg         (cfg)
   );

   aspl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .sts        (dp_sts),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   aspl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .now_us             (req_tdata[TIME_W-1:0]),
      .new_triggers       (req_tdata[TRIG_LSB +: TRIG_W]),
      .transition_pending (req_tdata[TP_BIT]),
      .transition_time_us (req_tdata[TT_LSB +: TIME_W]),
      .sts                (dp_sts),
      .level              (level),
      .one_shot_running   (one_shot_running)
   );

   assign rsp_tdata = {{(RSP_DW - RSP_USED){1'b0}}, one_shot_running, level};

   `ASPL_ASSERT_NEXT(a_one_tick_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "input taken again while a tick is in work")
   `ASPL_ASSERT_NOW(a_div_done_when_busy, clock, reset, dp_sts.div_done, !req_tready, "divider finished while the controller was idle")
   `ASPL_ASSERT_NEXT(a_out_load_shows_valid, clock, reset, cmd == CMD_OUT, rsp_tvalid, "result loaded but not presented")

endmodule

`default_nettype wire
